// ===== hw/rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths and types for the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int FIELD_W  = 18;                 // every matrix and quaternion field
	localparam int N_ENT    = 9;                  // matrix entries per request
	localparam int N_COMP   = 4;                  // quaternion components
	localparam int S_DATA_W = ((N_ENT * FIELD_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((N_COMP * FIELD_W + 7) / 8) * 8;

	// negation / permutation selects taken from the diagonal compares
	typedef struct packed {
		logic xy;
		logic yz;
		logic zx;
	} flags_t;

	// control that rides along the root and divide stages
	typedef struct packed {
		flags_t            flg;
		logic              bad;
		logic [N_COMP-1:0] sgn;
	} ctl_t;

	typedef struct packed {
		logic [M_DATA_W-1:0] data;
		logic                bad;
	} res_t;

endpackage

// ===== hw/rtl/rotation_matrix_to_quaternion_unit.sv =====
// Throughput: one request per cycle while s_tready is high (low while the skid register holds a result).
// Depth is set by the square root (one root bit per stage) and the four shared-step dividers
// (one quotient bit per stage).
// Reset (arst_n low) clears all valid bits, including the output and skid valid flags; payload is not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Branch-free 3x3 rotation matrix to unit quaternion, signed fixed point.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z (18b each), zero pad
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// quat_x, quat_y, quat_z, quat_w (18b each)
	output logic [M_DATA_W-1:0] m_tdata,
	// bad_matrix
	output logic                m_tuser
);

	localparam int RAD_W = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3;  // signed radicand
	localparam int NUM_W = RAD_W - 1;                                 // numerator magnitude
	localparam int SQ_W  = (NUM_W + FRAC_BITS + 1) / 2;               // root bits
	localparam int REM_W = SQ_W + 2;
	localparam int Q_W   = FRAC_BITS + 2;                             // quotient bits
	localparam int DV_W  = NUM_W + FRAC_BITS + 1;
	localparam int DS_W  = SQ_W + 1 + Q_W;
	localparam int DW    = (DV_W > DS_W) ? DV_W : DS_W;
	localparam int ADJ_W = FIELD_W + 1;
	localparam int DIF_W = FIELD_W + 2;
	localparam int CW    = Q_W + 1;

	localparam logic signed [RAD_W-1:0] ONE_RAD =
		{{(RAD_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [Q_W-1:0] ONE_Q = {2'b01, {FRAC_BITS{1'b0}}};

	typedef struct packed {
		ctl_t                          ctl;
		logic [N_COMP-1:0][NUM_W-1:0] mag;
	} side_t;

	logic adv;
	logic push;
	logic out_free;
	logic out_v_q;
	logic skid_v_q;
	res_t out_q;
	res_t skid_q;
	res_t res;

	assign adv      = !skid_v_q;
	assign s_tready = adv;

	// ---------------- stage 1: trace, flags, conditional negation ----------------
	logic signed [FIELD_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic signed [FIELD_W+1:0] tr;
	logic                      z_gt_x, z_gt_y, y_gt_x, tr_neg;
	flags_t                    flg;
	logic signed [ADJ_W-1:0]   e00, e11, e22, e10, e21, e02;

	assign m00 = s_tdata[0*FIELD_W +: FIELD_W];
	assign m01 = s_tdata[1*FIELD_W +: FIELD_W];
	assign m02 = s_tdata[2*FIELD_W +: FIELD_W];
	assign m10 = s_tdata[3*FIELD_W +: FIELD_W];
	assign m11 = s_tdata[4*FIELD_W +: FIELD_W];
	assign m12 = s_tdata[5*FIELD_W +: FIELD_W];
	assign m20 = s_tdata[6*FIELD_W +: FIELD_W];
	assign m21 = s_tdata[7*FIELD_W +: FIELD_W];
	assign m22 = s_tdata[8*FIELD_W +: FIELD_W];

	always_comb begin
		tr     = (FIELD_W+2)'(m00) + (FIELD_W+2)'(m11) + (FIELD_W+2)'(m22);
		tr_neg = tr[FIELD_W+1];
		z_gt_x = m22 > m00;
		z_gt_y = m22 > m11;
		y_gt_x = m11 > m00;
		flg.xy = tr_neg && (!z_gt_x || !z_gt_y);
		flg.yz = tr_neg && (y_gt_x || z_gt_x);
		flg.zx = tr_neg && (z_gt_y || !y_gt_x);
		e00 = ADJ_W'(m00);
		e11 = ADJ_W'(m11);
		e22 = ADJ_W'(m22);
		e10 = ADJ_W'(m10);
		e21 = ADJ_W'(m21);
		e02 = ADJ_W'(m02);
		if (flg.xy) begin
			e22 = -e22;
			e10 = -e10;
		end
		if (flg.yz) begin
			e00 = -e00;
			e21 = -e21;
		end
		if (flg.zx) begin
			e11 = -e11;
			e02 = -e02;
		end
	end

	logic                      v_s1;
	flags_t                    flg_s1;
	logic signed [ADJ_W-1:0]   d00_s1, d11_s1, d22_s1, n10_s1, n21_s1, n02_s1;
	logic signed [FIELD_W-1:0] m12_s1, m20_s1, m01_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flg_s1 <= flg;
			d00_s1 <= e00;
			d11_s1 <= e11;
			d22_s1 <= e22;
			n10_s1 <= e10;
			n21_s1 <= e21;
			n02_s1 <= e02;
			m12_s1 <= m12;
			m20_s1 <= m20;
			m01_s1 <= m01;
		end
	end

	// ---------------- stage 2: radicand and off-diagonal differences ----------------
	logic signed [RAD_W-1:0] rad;
	logic                    rad_bad;

	assign rad     = RAD_W'(d00_s1) + RAD_W'(d11_s1) + RAD_W'(d22_s1) + ONE_RAD;
	assign rad_bad = rad[RAD_W-1] || (rad == '0);

	logic                    v_s2;
	flags_t                  flg_s2;
	logic                    bad_s2;
	logic [NUM_W-1:0]        rad_s2;
	logic signed [DIF_W-1:0] dx_s2, dy_s2, dz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flg_s2 <= flg_s1;
			bad_s2 <= rad_bad;
			rad_s2 <= rad_bad ? '0 : rad[NUM_W-1:0];
			dx_s2  <= DIF_W'(m12_s1) - DIF_W'(n21_s1);
			dy_s2  <= DIF_W'(m20_s1) - DIF_W'(n02_s1);
			dz_s2  <= DIF_W'(m01_s1) - DIF_W'(n10_s1);
		end
	end

	// sign / magnitude split of the four numerators, w is the radicand
	side_t side_in;

	always_comb begin
		side_in.ctl.flg = flg_s2;
		side_in.ctl.bad = bad_s2;
		side_in.ctl.sgn = {1'b0, dz_s2[DIF_W-1], dy_s2[DIF_W-1], dx_s2[DIF_W-1]};
		side_in.mag[0]  = NUM_W'($unsigned(dx_s2[DIF_W-1] ? -dx_s2 : dx_s2));
		side_in.mag[1]  = NUM_W'($unsigned(dy_s2[DIF_W-1] ? -dy_s2 : dy_s2));
		side_in.mag[2]  = NUM_W'($unsigned(dz_s2[DIF_W-1] ? -dz_s2 : dz_s2));
		side_in.mag[3]  = rad_s2;
	end

	// ---------------- square root: one root bit per stage ----------------
	logic              sq_v_s    [SQ_W];
	logic [REM_W-1:0]  sq_rem_s  [SQ_W];
	logic [SQ_W-1:0]   sq_root_s [SQ_W];
	logic [2*SQ_W-1:0] sq_val_s  [SQ_W];
	side_t             sq_side_s [SQ_W];

	for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
		logic              v_i;
		logic [REM_W-1:0]  rem_i;
		logic [SQ_W-1:0]   root_i;
		logic [2*SQ_W-1:0] val_i;
		side_t             side_i;
		logic [REM_W+1:0]  cur;
		logic [REM_W+1:0]  trial;

		if (k == 0) begin : g_first
			assign v_i    = v_s2;
			assign rem_i  = '0;
			assign root_i = '0;
			assign val_i  = (2*SQ_W)'({rad_s2, {FRAC_BITS{1'b0}}});
			assign side_i = side_in;
		end else begin : g_next
			assign v_i    = sq_v_s[k-1];
			assign rem_i  = sq_rem_s[k-1];
			assign root_i = sq_root_s[k-1];
			assign val_i  = sq_val_s[k-1];
			assign side_i = sq_side_s[k-1];
		end

		assign cur   = {rem_i, val_i[2*SQ_W-1 -: 2]};
		assign trial = (REM_W+2)'({root_i, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k] <= 1'b0;
			end else if (adv) begin
				sq_v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (cur >= trial) begin
					sq_rem_s[k]  <= REM_W'(cur - trial);
					sq_root_s[k] <= {root_i[SQ_W-2:0], 1'b1};
				end else begin
					sq_rem_s[k]  <= REM_W'(cur);
					sq_root_s[k] <= {root_i[SQ_W-2:0], 1'b0};
				end
				sq_val_s[k]  <= val_i << 2;
				sq_side_s[k] <= side_i;
			end
		end
	end

	// ---------------- divide prep: numerator with rounding term, divisor 2s ----------------
	logic [SQ_W-1:0]             root;
	logic                        v_sp;
	ctl_t                        ctl_sp;
	logic [SQ_W:0]               den_sp;
	logic [N_COMP-1:0][DW-1:0]   num_sp;

	assign root = sq_root_s[SQ_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sp <= 1'b0;
		end else if (adv) begin
			v_sp <= sq_v_s[SQ_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_sp <= sq_side_s[SQ_W-1].ctl;
			den_sp <= {root, 1'b0};
			for (int j = 0; j < N_COMP; j++) begin
				num_sp[j] <= DW'({sq_side_s[SQ_W-1].mag[j], {FRAC_BITS{1'b0}}}) + DW'(root);
			end
		end
	end

	// ---------------- overflow check: quotient would not fit Q_W bits ----------------
	logic [DW-1:0]             den_lim;
	logic                      v_sc;
	ctl_t                      ctl_sc;
	logic [SQ_W:0]             den_sc;
	logic [N_COMP-1:0][DW-1:0] num_sc;
	logic [N_COMP-1:0]         ovf_sc;

	assign den_lim = DW'(den_sp) << Q_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sc <= 1'b0;
		end else if (adv) begin
			v_sc <= v_sp;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_sc <= ctl_sp;
			den_sc <= den_sp;
			num_sc <= num_sp;
			for (int j = 0; j < N_COMP; j++) begin
				ovf_sc[j] <= num_sp[j] >= den_lim;
			end
		end
	end

	// ---------------- restoring divide: one quotient bit per stage, four lanes ----------------
	logic                       dv_v_s   [Q_W];
	ctl_t                       dv_ctl_s [Q_W];
	logic [SQ_W:0]              dv_den_s [Q_W];
	logic [N_COMP-1:0][DW-1:0]  dv_rem_s [Q_W];
	logic [N_COMP-1:0][Q_W-1:0] dv_q_s   [Q_W];
	logic [N_COMP-1:0]          dv_ovf_s [Q_W];

	for (genvar i = 0; i < Q_W; i++) begin : g_div
		localparam int B = Q_W - 1 - i;

		logic                       v_i;
		ctl_t                       ctl_i;
		logic [SQ_W:0]              den_i;
		logic [N_COMP-1:0][DW-1:0]  rem_i;
		logic [N_COMP-1:0][DW-1:0]  rem_o;
		logic [N_COMP-1:0][Q_W-1:0] q_i;
		logic [N_COMP-1:0][Q_W-1:0] q_o;
		logic [N_COMP-1:0]          ovf_i;
		logic [DW-1:0]              dsh;

		if (i == 0) begin : g_first
			assign v_i   = v_sc;
			assign ctl_i = ctl_sc;
			assign den_i = den_sc;
			assign rem_i = num_sc;
			assign q_i   = '0;
			assign ovf_i = ovf_sc;
		end else begin : g_next
			assign v_i   = dv_v_s[i-1];
			assign ctl_i = dv_ctl_s[i-1];
			assign den_i = dv_den_s[i-1];
			assign rem_i = dv_rem_s[i-1];
			assign q_i   = dv_q_s[i-1];
			assign ovf_i = dv_ovf_s[i-1];
		end

		assign dsh = DW'(den_i) << B;

		always_comb begin
			for (int j = 0; j < N_COMP; j++) begin
				if (rem_i[j] >= dsh) begin
					rem_o[j] = rem_i[j] - dsh;
					q_o[j]   = {q_i[j][Q_W-2:0], 1'b1};
				end else begin
					rem_o[j] = rem_i[j];
					q_o[j]   = {q_i[j][Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[i] <= 1'b0;
			end else if (adv) begin
				dv_v_s[i] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ctl_s[i] <= ctl_i;
				dv_den_s[i] <= den_i;
				dv_rem_s[i] <= rem_o;
				dv_q_s[i]   <= q_o;
				dv_ovf_s[i] <= ovf_i;
			end
		end
	end

	// ---------------- clamp, sign, permute ----------------
	ctl_t                           ctl_f;
	logic [N_COMP-1:0][Q_W-1:0]     q_f;
	logic [N_COMP-1:0]              ovf_f;
	logic [Q_W-1:0]                 mag;
	logic signed [CW-1:0]           sval;
	logic [N_COMP-1:0][FIELD_W-1:0] comp;
	logic [N_COMP-1:0][FIELD_W-1:0] perm;
	logic [N_COMP-1:0][FIELD_W-1:0] quat;

	assign ctl_f = dv_ctl_s[Q_W-1];
	assign q_f   = dv_q_s[Q_W-1];
	assign ovf_f = dv_ovf_s[Q_W-1];

	always_comb begin
		mag  = '0;
		sval = '0;
		for (int j = 0; j < N_COMP; j++) begin
			mag     = (ovf_f[j] || (q_f[j] > ONE_Q)) ? ONE_Q : q_f[j];
			sval    = ctl_f.sgn[j] ? -CW'(mag) : CW'(mag);
			comp[j] = ctl_f.bad ? '0 : FIELD_W'(sval);
		end
		perm = comp;
		if (ctl_f.flg.xy) begin
			perm[0] = comp[3];
			perm[1] = comp[2];
			perm[2] = comp[1];
			perm[3] = comp[0];
		end
		quat = perm;
		if (ctl_f.flg.yz) begin
			quat[0] = perm[1];
			quat[1] = perm[0];
			quat[2] = perm[3];
			quat[3] = perm[2];
		end
		res.data = M_DATA_W'(quat);
		res.bad  = ctl_f.bad;
	end

	// ---------------- output register with skid ----------------
	assign push     = adv && dv_v_s[Q_W-1];
	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_v_q  <= skid_v_q || push;
				skid_v_q <= 1'b0;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// skid is only loaded while the pipe still advances, so it is empty on a push
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q.data;
	assign m_tuser  = out_q.bad;

endmodule

// ===== hw/rtl/rmq_chk.sv =====
// ----------------------------------------------------------------------------
// rmq_chk
// Port-level checks for the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
module rmq_chk
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [S_DATA_W-1:0] s_tdata,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tuser
);

	localparam int LIM = (FRAC_BITS > 16) ? 0 : (1 << FRAC_BITS);

	function automatic logic in_rng(input logic [FIELD_W-1:0] v);
		in_rng = ($signed(v) <= LIM) && ($signed(v) >= -LIM);
	endfunction

	// a waiting request stays put
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("request changed while waiting");

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// bad radicand gives all-zero components
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("bad_matrix with nonzero components");

	// input side only backs up when a stalled result forced the skid to fill
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("s_tready dropped without output stall");

	// components saturate to -1..1
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (FRAC_BITS > 16) ||
			(in_rng(m_tdata[17:0]) && in_rng(m_tdata[35:18]) &&
			 in_rng(m_tdata[53:36]) && in_rng(m_tdata[71:54])))
		else $error("component out of range");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_chk #(.FRAC_BITS(FRAC_BITS)) u_rmq_chk (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rotation_matrix_to_quaternion_unit. Each request is
// predicted in the bench as it is accepted. Every returned quaternion is
// compared field by field against the oldest prediction. Stimulus is a
// directed set, then random rotations and raw matrices under random or forced
// back-pressure.
// ----------------------------------------------------------------------------
module testbench;
	import rmq_pkg::*;

	localparam int FRAC_BITS      = 16;
	localparam int ONE_Q          = 1 << FRAC_BITS;
	localparam int MAX_E          = 131071;   // largest 18-bit entry
	localparam int MIN_E          = -131072;  // smallest 18-bit entry
	localparam int MAX_REPORTS    = 10;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 60;

	typedef logic [N_ENT*FIELD_W-1:0] mat_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;

	res_t expected_quats[$];
	int   mismatches     = 0;
	int   idle_cycles    = 0;
	int   tx_gap_max     = 8;
	int   rx_stall_max   = 8;
	int   holdoff_cycles = 0;

	rotation_matrix_to_quaternion_unit #(
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// quaternion predictor
	// ------------------------------------------------------------------
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v    = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// num / (2*root) in Q.FRAC_BITS, rounded half away from zero, clamped to +-1
	function automatic longint scaled_quotient(input longint num, input longint unsigned root);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? longint'(-num) : num;
		q   = ((mag << FRAC_BITS) + root) / (2 * root);
		if (q > ONE_Q)
			q = ONE_Q;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic res_t predict_quat(input mat_t mat);
		longint          a[N_ENT];
		longint          tr, rad, cx, cy, cz, cw, ox, oy, oz, ow, t;
		longint unsigned root;
		logic            neg, z_gt_x, z_gt_y, y_gt_x;
		flags_t          f;
		res_t            r;
		// a[3*column + row]
		for (int i = 0; i < N_ENT; i++)
			a[i] = longint'($signed(mat[i*FIELD_W +: FIELD_W]));
		tr     = a[0] + a[4] + a[8];
		neg    = tr < 0;
		z_gt_x = a[8] > a[0];
		z_gt_y = a[8] > a[4];
		y_gt_x = a[4] > a[0];
		f.xy   = (!z_gt_x || !z_gt_y) && neg;
		f.yz   = (y_gt_x || z_gt_x) && neg;
		f.zx   = (z_gt_y || !y_gt_x) && neg;
		if (f.xy) begin
			a[8] = -a[8];
			a[3] = -a[3];
		end
		if (f.yz) begin
			a[0] = -a[0];
			a[7] = -a[7];
		end
		if (f.zx) begin
			a[4] = -a[4];
			a[2] = -a[2];
		end
		r.data = '0;
		r.bad  = 1'b0;
		rad = a[0] + a[4] + a[8] + ONE_Q;
		// cannot go non-positive for 18-bit inputs, kept for completeness
		if (rad <= 0) begin
			r.bad = 1'b1;
			return r;
		end
		root = int_sqrt(longint'(rad) << FRAC_BITS);
		cx = scaled_quotient(a[5] - a[7], root);
		cy = scaled_quotient(a[6] - a[2], root);
		cz = scaled_quotient(a[1] - a[3], root);
		cw = scaled_quotient(rad, root);
		ox = cx;
		oy = cy;
		oz = cz;
		ow = cw;
		if (f.xy) begin
			ox = cw;
			oy = cz;
			oz = cy;
			ow = cx;
		end
		if (f.yz) begin
			t  = ox;
			ox = oy;
			oy = t;
			t  = oz;
			oz = ow;
			ow = t;
		end
		r.data[0*FIELD_W +: FIELD_W] = ox[FIELD_W-1:0];
		r.data[1*FIELD_W +: FIELD_W] = oy[FIELD_W-1:0];
		r.data[2*FIELD_W +: FIELD_W] = oz[FIELD_W-1:0];
		r.data[3*FIELD_W +: FIELD_W] = ow[FIELD_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// matrix builders
	// ------------------------------------------------------------------
	function automatic mat_t make_mat(input int c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z);
		return {c2z[FIELD_W-1:0], c2y[FIELD_W-1:0], c2x[FIELD_W-1:0],
			c1z[FIELD_W-1:0], c1y[FIELD_W-1:0], c1x[FIELD_W-1:0],
			c0z[FIELD_W-1:0], c0y[FIELD_W-1:0], c0x[FIELD_W-1:0]};
	endfunction

	function automatic real rand_unit();
		return ($itor($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0;
	endfunction

	function automatic int to_fixed(input real v);
		int q;
		q = $rtoi(v * 65536.0 + ((v < 0.0) ? -0.5 : 0.5));
		if (q > ONE_Q)
			q = ONE_Q;
		if (q < -ONE_Q)
			q = -ONE_Q;
		return q;
	endfunction

	// rotation matrix from a random unit quaternion
	function automatic mat_t random_rotation();
		real qx, qy, qz, qw, n;
		qx = rand_unit();
		qy = rand_unit();
		qz = rand_unit();
		qw = rand_unit();
		n  = $sqrt(qx*qx + qy*qy + qz*qz + qw*qw);
		if (n < 1.0e-3) begin
			qx = 0.0;
			qy = 0.0;
			qz = 0.0;
			qw = 1.0;
			n  = 1.0;
		end
		qx = qx / n;
		qy = qy / n;
		qz = qz / n;
		qw = qw / n;
		return make_mat(
			to_fixed(1.0 - 2.0*(qy*qy + qz*qz)), to_fixed(2.0*(qx*qy + qz*qw)),
			to_fixed(2.0*(qx*qz - qy*qw)),
			to_fixed(2.0*(qx*qy - qz*qw)), to_fixed(1.0 - 2.0*(qx*qx + qz*qz)),
			to_fixed(2.0*(qy*qz + qx*qw)),
			to_fixed(2.0*(qx*qz + qy*qw)), to_fixed(2.0*(qy*qz - qx*qw)),
			to_fixed(1.0 - 2.0*(qx*qx + qy*qy)));
	endfunction

	function automatic mat_t random_matrix(input bit full_width);
		mat_t m;
		for (int i = 0; i < N_ENT; i++) begin
			if (full_width)
				m[i*FIELD_W +: FIELD_W] = FIELD_W'($urandom_range(0, (1 << FIELD_W) - 1));
			else
				m[i*FIELD_W +: FIELD_W] =
					FIELD_W'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
		end
		return m;
	endfunction

	function automatic mat_t random_mixed();
		int unsigned kind;
		kind = $urandom_range(0, 99);
		if (kind < 60)
			return random_rotation();
		else if (kind < 85)
			return random_matrix(1'b0);
		else
			return random_matrix(1'b1);
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------
	task automatic send_matrix(input mat_t mat);
		int unsigned gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W - N_ENT*FIELD_W){1'b0}}, mat};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_quats.push_back(predict_quat(mat));
	endtask

	task automatic wait_quats_drained();
		s_tvalid <= 1'b0;
		while (expected_quats.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------
	initial begin
		int unsigned stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holdoff_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (holdoff_cycles) @(posedge clk);
				holdoff_cycles = 0;
			end
			stall = $urandom_range(0, rx_stall_max);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid && holdoff_cycles == 0)
				@(posedge clk);
		end
	end

	function automatic void note_mismatch(input string what, input longint want, input longint got);
		if (mismatches < MAX_REPORTS)
			$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
		mismatches++;
	endfunction

	always @(posedge clk) begin : check_quats
		res_t want;
		if (m_tvalid && m_tready) begin
			if (expected_quats.size() == 0) begin
				note_mismatch("unexpected result, quat_x", 0,
					$signed(m_tdata[0 +: FIELD_W]));
			end else begin
				want = expected_quats.pop_front();
				for (int k = 0; k < N_COMP; k++) begin
					if (m_tdata[k*FIELD_W +: FIELD_W] !== want.data[k*FIELD_W +: FIELD_W])
						note_mismatch($sformatf("quaternion component %0d", k),
							$signed(want.data[k*FIELD_W +: FIELD_W]),
							$signed(m_tdata[k*FIELD_W +: FIELD_W]));
				end
				if (m_tuser !== want.bad)
					note_mismatch("bad_matrix", want.bad, m_tuser);
			end
		end
	end

	// ends the run with a failure when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		// identity, zero matrix, half turns and quarter turns about each axis
		send_matrix(make_mat(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
		send_matrix(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_matrix(make_mat(ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
		send_matrix(make_mat(-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q));
		send_matrix(make_mat(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q));
		send_matrix(make_mat(0, ONE_Q, 0, -ONE_Q, 0, 0, 0, 0, ONE_Q));
		send_matrix(make_mat(ONE_Q, 0, 0, 0, 0, ONE_Q, 0, -ONE_Q, 0));
		send_matrix(make_mat(0, 0, -ONE_Q, 0, ONE_Q, 0, ONE_Q, 0, 0));
		// all three diagonal entries tied, negative trace
		send_matrix(make_mat(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
		// two-way ties on the diagonal
		send_matrix(make_mat(-100, 300, -700, 1200, -100, 50, -9000, 20, -500));
		send_matrix(make_mat(-900, -40, 800, 300, -100, -60, 7000, 11, -100));
		send_matrix(make_mat(-100, 5, 6, 7, -900, 8, 9, 10, -100));
		// trace just below zero and exactly zero
		send_matrix(make_mat(0, 123, -321, 40, 0, 77, -5, 9, -1));
		send_matrix(make_mat(ONE_Q/2, 1000, 0, -1000, -ONE_Q/2, 0, 0, 0, 0));
		// field extremes beyond -1..1, outputs saturate
		send_matrix(make_mat(MAX_E, MAX_E, MAX_E, MAX_E, MAX_E, MAX_E, MAX_E, MAX_E, MAX_E));
		send_matrix(make_mat(MIN_E, MIN_E, MIN_E, MIN_E, MIN_E, MIN_E, MIN_E, MIN_E, MIN_E));
		send_matrix(make_mat(MIN_E, MAX_E, MIN_E, MIN_E, MIN_E, MAX_E, MAX_E, MIN_E, MIN_E));
		send_matrix(make_mat(0, MAX_E, MIN_E, MIN_E, 0, MAX_E, MAX_E, MIN_E, 0));
		send_matrix(make_mat(MAX_E, MIN_E, MAX_E, MAX_E, MIN_E, MIN_E, MIN_E, MAX_E, MIN_E));
		// alternating bit patterns
		send_matrix(make_mat('h15555, 'h15555, 'h15555, 'h15555, 'h15555,
			'h15555, 'h15555, 'h15555, 'h15555));
		send_matrix(make_mat('h2AAAA, 'h2AAAA, 'h2AAAA, 'h2AAAA, 'h2AAAA,
			'h2AAAA, 'h2AAAA, 'h2AAAA, 'h2AAAA));
		wait_quats_drained();
	endtask

	task automatic test_full_rate();
		tx_gap_max   = 0;
		rx_stall_max = 0;
		repeat (150) send_matrix(random_rotation());
		wait_quats_drained();
		tx_gap_max   = 8;
		rx_stall_max = 8;
	endtask

	// receiver holds off long enough for the pipe to fill and stall requests
	task automatic test_receiver_holdoff();
		tx_gap_max     = 0;
		holdoff_cycles = 400;
		repeat (150) send_matrix(random_mixed());
		tx_gap_max = 8;
		wait_quats_drained();
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < 700; i++) begin
			send_matrix(random_mixed());
			if (i % 175 == 174)
				wait_quats_drained();
		end
		wait_quats_drained();
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		arst_n   <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_rate();
		test_receiver_holdoff();
		test_random_mix();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_quats.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
